// ===== rtl/sst_pkg.sv =====
`default_nettype none

package sst_pkg;

   // Default table geometry
   localparam int KEY_COUNT_DEF = 256;
   localparam int CAPACITY_DEF  = 64;
   localparam int DATA_BITS_DEF = 32;

   // Request kinds
   typedef enum logic [2:0] {
      KIND_INSERT = 3'd0,
      KIND_REMOVE = 3'd1,
      KIND_LOOKUP = 3'd2,
      KIND_READ   = 3'd3,
      KIND_CLEAR  = 3'd4
   } sst_kind_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_FULL     = 3'd3,
      ST_RANGE    = 3'd4
   } sst_status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK1,
      S_LOOK2,
      S_READ1,
      S_CHECK,
      S_SHIFT,
      S_RESP
   } sst_state_type;

   // Source of the dense-array read address
   typedef enum logic [1:0] {
      PRD_KP,
      PRD_REQ,
      PRD_KP_NEXT,
      PRD_SKIP
   } sst_prd_sel_type;

   // Which result fields get filled
   typedef enum logic [2:0] {
      FILL_NONE,
      FILL_DUP,
      FILL_INSERT,
      FILL_LOOKUP,
      FILL_READ
   } sst_fill_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  key;
      logic [31:0] value;
      logic [5:0]  position;
   } sst_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [7:0]  key_out;
      logic [31:0] value_out;
      logic [5:0]  position_out;
      logic [6:0]  count;
   } sst_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic            capture;
      sst_prd_sel_type prd_sel;
      logic            ins_write;
      logic            shift_write;
      logic            idx_load;
      logic            count_dec;
      logic            count_clear;
      logic            res_load;
      sst_status_type  res_status;
      sst_fill_type    res_fill;
      logic            rsp_load;
   } sst_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [2:0] kind;
      logic       key_ok;
      logic       hit;
      logic       full;
      logic       in_range;
      logic       more_first;
      logic       more_next;
   } sst_stat_type;

endpackage

`default_nettype wire

// ===== rtl/sst_ctrl.sv =====
`default_nettype none

module sst_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [2:0]         req_kind,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire sst_pkg::sst_stat_type st,
   output sst_pkg::sst_cmd_type    cmd
);
   import sst_pkg::*;

   sst_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (sst_kind_type'(req_kind))
                  KIND_INSERT, KIND_REMOVE, KIND_LOOKUP: state_in = S_LOOK1;
                  KIND_READ: state_in = S_READ1;
                  default:   state_in = S_CHECK;
               endcase
            end
         end
         S_LOOK1: state_in = S_LOOK2;
         S_LOOK2: state_in = S_CHECK;
         S_READ1: state_in = S_CHECK;
         S_CHECK: begin
            if (sst_kind_type'(st.kind) == KIND_REMOVE && st.hit && st.more_first) begin
               state_in = S_SHIFT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SHIFT: begin
            if (!st.more_next) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd            = '0;
      cmd.prd_sel    = PRD_KP;
      cmd.res_status = ST_OK;
      cmd.res_fill   = FILL_NONE;
      unique case (state_ff)
         S_IDLE: cmd.capture = req_valid;
         S_LOOK1: ;
         S_LOOK2: cmd.prd_sel = PRD_KP;
         S_READ1: cmd.prd_sel = PRD_REQ;
         S_CHECK: begin
            cmd.res_load = 1'b1;
            unique case (sst_kind_type'(st.kind))
               KIND_INSERT: begin
                  priority if (!st.key_ok) begin
                     cmd.res_status = ST_NOTFOUND;
                  end else if (st.hit) begin
                     cmd.res_status = ST_DUP;
                     cmd.res_fill   = FILL_DUP;
                  end else if (st.full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.ins_write = 1'b1;
                     cmd.res_fill  = FILL_INSERT;
                  end
               end
               KIND_REMOVE: begin
                  if (st.hit) begin
                     if (st.more_first) begin
                        cmd.idx_load = 1'b1;
                        cmd.prd_sel  = PRD_KP_NEXT;
                     end else begin
                        cmd.count_dec = 1'b1;
                     end
                  end else begin
                     cmd.res_status = ST_NOTFOUND;
                  end
               end
               KIND_LOOKUP: begin
                  if (st.hit) begin
                     cmd.res_fill = FILL_LOOKUP;
                  end else begin
                     cmd.res_status = ST_NOTFOUND;
                  end
               end
               KIND_READ: begin
                  if (st.in_range) begin
                     cmd.res_fill = FILL_READ;
                  end else begin
                     cmd.res_status = ST_RANGE;
                  end
               end
               KIND_CLEAR: cmd.count_clear = 1'b1;
               default: ;
            endcase
         end
         S_SHIFT: begin
            cmd.shift_write = 1'b1;
            if (st.more_next) begin
               cmd.prd_sel = PRD_SKIP;
            end else begin
               cmd.count_dec = 1'b1;
            end
         end
         S_RESP: cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Hold the result valid until the transfer completes
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/sst_datapath.sv =====
`default_nettype none

module sst_datapath #(
   parameter int KEY_COUNT = sst_pkg::KEY_COUNT_DEF,
   parameter int CAPACITY  = sst_pkg::CAPACITY_DEF,
   parameter int DATA_BITS = sst_pkg::DATA_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sst_pkg::sst_cmd_type cmd,
   output sst_pkg::sst_stat_type     st,
   input  wire sst_pkg::sst_req_type req_data,
   output sst_pkg::sst_rsp_type      rsp_data
);
   import sst_pkg::*;

   localparam int KW   = $clog2(KEY_COUNT);
   localparam int PW   = $clog2(CAPACITY);
   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int XW   = CNTW + 1;

   // Storage
   logic [PW-1:0]        k2p_mem [KEY_COUNT];
   logic [KW-1:0]        pkey_mem [CAPACITY];
   logic [DATA_BITS-1:0] pval_mem [CAPACITY];

   sst_req_type          req_ff;
   logic [CNTW-1:0]      count_ff, count_in;
   logic [PW-1:0]        idx_ff, idx_in;
   logic [PW-1:0]        kp_rd_ff;
   logic [KW-1:0]        pk_rd_ff;
   logic [DATA_BITS-1:0] pv_rd_ff;
   sst_rsp_type          res_ff, res_in;
   sst_rsp_type          rsp_ff, rsp_in;

   logic [KW-1:0]        req_key_idx;
   logic [PW-1:0]        prd_addr;
   logic                 k2p_we;
   logic [KW-1:0]        k2p_waddr;
   logic [PW-1:0]        k2p_wdata;
   logic                 pos_we;
   logic [PW-1:0]        pos_waddr;
   logic [KW-1:0]        pkey_wdata;
   logic [DATA_BITS-1:0] pval_wdata;

   assign req_key_idx = KW'(req_ff.key);

   // Dense-array read address
   always_comb begin
      unique case (cmd.prd_sel)
         PRD_KP:      prd_addr = kp_rd_ff;
         PRD_REQ:     prd_addr = PW'(req_ff.position);
         PRD_KP_NEXT: prd_addr = kp_rd_ff + PW'(1);
         PRD_SKIP:    prd_addr = idx_ff + PW'(2);
         default:     prd_addr = kp_rd_ff;
      endcase
   end

   // Write ports: append on insert, shift down on remove
   always_comb begin
      k2p_we     = cmd.ins_write || cmd.shift_write;
      pos_we     = cmd.ins_write || cmd.shift_write;
      if (cmd.ins_write) begin
         k2p_waddr  = req_key_idx;
         k2p_wdata  = PW'(count_ff);
         pos_waddr  = PW'(count_ff);
         pkey_wdata = req_key_idx;
         pval_wdata = DATA_BITS'(req_ff.value);
      end else begin
         k2p_waddr  = pk_rd_ff;
         k2p_wdata  = idx_ff;
         pos_waddr  = idx_ff;
         pkey_wdata = pk_rd_ff;
         pval_wdata = pv_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (k2p_we) begin
         k2p_mem[k2p_waddr] <= k2p_wdata;
      end
      kp_rd_ff <= k2p_mem[req_key_idx];
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pkey_mem[pos_waddr] <= pkey_wdata;
         pval_mem[pos_waddr] <= pval_wdata;
      end
      pk_rd_ff <= pkey_mem[prd_addr];
      pv_rd_ff <= pval_mem[prd_addr];
   end

   // Entry count and shift index
   always_comb begin
      priority if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.ins_write) begin
         count_in = count_ff + CNTW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNTW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      priority if (cmd.idx_load) begin
         idx_in = kp_rd_ff;
      end else if (cmd.shift_write) begin
         idx_in = idx_ff + PW'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // Status toward the controller
   always_comb begin
      st.kind       = req_ff.kind;
      st.key_ok     = int'(req_ff.key) < KEY_COUNT;
      st.hit        = st.key_ok && (CNTW'(kp_rd_ff) < count_ff) && (pk_rd_ff == req_key_idx);
      st.full       = int'(count_ff) >= CAPACITY;
      st.in_range   = int'(req_ff.position) < int'(count_ff);
      st.more_first = (XW'(kp_rd_ff) + XW'(1)) < XW'(count_ff);
      st.more_next  = (XW'(idx_ff) + XW'(2)) < XW'(count_ff);
   end

   // Result fields
   always_comb begin
      res_in        = '0;
      res_in.status = cmd.res_status;
      unique case (cmd.res_fill)
         FILL_NONE: ;
         FILL_DUP:  res_in.position_out = 6'(kp_rd_ff);
         FILL_INSERT: res_in.position_out = 6'(count_ff);
         FILL_LOOKUP: begin
            res_in.found        = 1'b1;
            res_in.position_out = 6'(kp_rd_ff);
            res_in.value_out    = 32'(pv_rd_ff);
         end
         FILL_READ: begin
            res_in.key_out   = 8'(pk_rd_ff);
            res_in.value_out = 32'(pv_rd_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_ff <= res_in;
      end
   end

   // Output register, count taken once the item has finished
   always_comb begin
      rsp_in       = res_ff;
      rsp_in.count = 7'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/sparse_set_table.sv =====
// Steps: insert, remove and lookup pass S_LOOK1, S_LOOK2, S_CHECK; read by position
// S_READ1, S_CHECK; clear S_CHECK alone; a remove with later entries then shifts them
// down in S_SHIFT, one entry per cycle; all end in S_RESP, which loads the output register.
// A new request is taken only in S_IDLE, once the last one has left S_RESP.
// Reset: synchronous; empties the table at once, no clearing pass.
`default_nettype none

module sparse_set_table #(
   parameter int KEY_COUNT = sst_pkg::KEY_COUNT_DEF,
   parameter int CAPACITY  = sst_pkg::CAPACITY_DEF,
   parameter int DATA_BITS = sst_pkg::DATA_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sst_pkg::sst_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sst_pkg::sst_rsp_type      rsp_data
);
   import sst_pkg::*;

   sst_cmd_type  cmd;
   sst_stat_type st;

   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   sst_datapath #(
      .KEY_COUNT (KEY_COUNT),
      .CAPACITY  (CAPACITY),
      .DATA_BITS (DATA_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .st       (st),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import sst_pkg::*;

   localparam int          LIMIT_CYCLES     = 1_000_000;
   localparam int          DRAIN_CYCLES     = 80;
   localparam int          HOLD_OFF_CYCLES  = 400;
   localparam int          RANDOM_ITEMS     = 1700;
   localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   sst_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   sst_rsp_type rsp_data;

   // Shadow copy of the table contents
   logic        key_valid  [KEY_COUNT_DEF];
   logic [5:0]  key_slot   [KEY_COUNT_DEF];
   logic [7:0]  slot_key   [CAPACITY_DEF];
   logic [31:0] slot_value [CAPACITY_DEF];
   int          entry_total;

   sst_rsp_type pending_results[$];
   int          mismatch_count;
   int          burst_left;
   int          hold_request;
   int          cycle_count;

   sparse_set_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Apply one accepted request to the shadow table and return its result
   function automatic sst_rsp_type table_result(input sst_req_type r);
      sst_rsp_type res;
      int          slot;
      res = '0;
      case (r.kind)
         KIND_INSERT: begin
            if (key_valid[r.key]) begin
               res.status       = ST_DUP;
               res.position_out = key_slot[r.key];
            end else if (entry_total >= CAPACITY_DEF) begin
               res.status = ST_FULL;
            end else begin
               slot_key[entry_total]   = r.key;
               slot_value[entry_total] = r.value;
               key_slot[r.key]         = 6'(entry_total);
               key_valid[r.key]        = 1'b1;
               res.position_out        = 6'(entry_total);
               entry_total++;
            end
         end
         KIND_REMOVE: begin
            if (!key_valid[r.key]) begin
               res.status = ST_NOTFOUND;
            end else begin
               // shift later entries down one place, keeping order
               for (slot = int'(key_slot[r.key]); slot + 1 < entry_total; slot++) begin
                  slot_key[slot]           = slot_key[slot + 1];
                  slot_value[slot]         = slot_value[slot + 1];
                  key_slot[slot_key[slot]] = 6'(slot);
               end
               key_valid[r.key] = 1'b0;
               key_slot[r.key]  = '0;
               entry_total--;
            end
         end
         KIND_LOOKUP: begin
            if (!key_valid[r.key]) begin
               res.status = ST_NOTFOUND;
            end else begin
               res.found        = 1'b1;
               res.position_out = key_slot[r.key];
               res.value_out    = slot_value[key_slot[r.key]];
            end
         end
         KIND_READ: begin
            if (r.position >= entry_total) begin
               res.status = ST_RANGE;
            end else begin
               res.key_out   = slot_key[r.position];
               res.value_out = slot_value[r.position];
            end
         end
         KIND_CLEAR: begin
            foreach (key_valid[k]) key_valid[k] = 1'b0;
            entry_total = 0;
         end
         default: ;
      endcase
      res.count = 7'(entry_total);
      return res;
   endfunction

   function automatic sst_req_type make_request(input logic [2:0] kind, input logic [7:0] key,
                                                input logic [31:0] value,
                                                input logic [5:0] position);
      sst_req_type r;
      r.kind     = kind;
      r.key      = key;
      r.value    = value;
      r.position = position;
      return r;
   endfunction

   // Pick a request; removes and lookups favor keys that are present
   function automatic sst_req_type random_request(input int insert_pct, input int key_span);
      sst_req_type r;
      int          pick;
      int          top;
      r.kind     = KIND_LOOKUP;
      r.key      = 8'($urandom_range(0, key_span - 1));
      r.value    = $urandom;
      r.position = 6'($urandom);
      if ($urandom_range(0, 99) < insert_pct) begin
         r.kind = KIND_INSERT;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            r.kind = (pick < 35) ? KIND_REMOVE : KIND_LOOKUP;
            if (entry_total > 0 && $urandom_range(0, 3) != 0)
               r.key = slot_key[$urandom_range(0, entry_total - 1)];
         end else if (pick < 95) begin
            r.kind = KIND_READ;
            top    = (entry_total > 63) ? 63 : entry_total;
            if ($urandom_range(0, 3) != 0)
               r.position = 6'($urandom_range(0, top));
         end else if (pick < 98) begin
            r.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
         end else begin
            r.kind = KIND_CLEAR;
         end
      end
      return r;
   endfunction

   // Offer one request, wait for its transfer, then record the result it owes.
   // Entered and left just after a falling edge.
   task automatic push_request(input sst_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pending_results.insert(pending_results.size(), table_result(r));
      @(negedge clock);
   endtask

   task automatic test_directed_cases();
      int k;
      // empty table
      push_request(make_request(KIND_LOOKUP, 8'h00, 32'h0, 6'd0));
      push_request(make_request(KIND_REMOVE, 8'hff, 32'h0, 6'd0));
      push_request(make_request(KIND_READ, 8'h00, 32'h0, 6'd0));
      // field extremes and a duplicate
      push_request(make_request(KIND_INSERT, 8'h00, 32'h0000_0000, 6'd0));
      push_request(make_request(KIND_INSERT, 8'hff, 32'hffff_ffff, 6'd63));
      push_request(make_request(KIND_INSERT, 8'h5a, 32'ha5a5_a5a5, 6'd21));
      push_request(make_request(KIND_INSERT, 8'h00, 32'h0000_0001, 6'd0));
      push_request(make_request(KIND_LOOKUP, 8'hff, 32'h0, 6'd0));
      push_request(make_request(KIND_LOOKUP, 8'h5a, 32'hffff_ffff, 6'd63));
      push_request(make_request(KIND_READ, 8'h00, 32'h0, 6'd0));
      push_request(make_request(KIND_READ, 8'hff, 32'h0, 6'd2));
      push_request(make_request(KIND_READ, 8'h00, 32'h0, 6'd3));
      push_request(make_request(KIND_READ, 8'h00, 32'h0, 6'd63));
      // remove the head entry, then check that the rest moved down
      push_request(make_request(KIND_REMOVE, 8'h00, 32'h0, 6'd0));
      push_request(make_request(KIND_LOOKUP, 8'hff, 32'h0, 6'd0));
      push_request(make_request(KIND_READ, 8'h00, 32'h0, 6'd1));
      push_request(make_request(KIND_REMOVE, 8'h00, 32'h0, 6'd0));
      push_request(make_request(KIND_LOOKUP, 8'h00, 32'h0, 6'd0));
      // unused kinds leave the table alone
      for (k = int'(KIND_SPARE_FIRST); k <= int'(KIND_SPARE_LAST); k++)
         push_request(make_request(3'(k), 8'($urandom), $urandom, 6'($urandom)));
      push_request(make_request(KIND_CLEAR, 8'h5a, 32'h0, 6'd0));
      push_request(make_request(KIND_LOOKUP, 8'hff, 32'h0, 6'd0));
      push_request(make_request(KIND_READ, 8'h00, 32'h0, 6'd0));
      push_request(make_request(KIND_INSERT, 8'h07, 32'h1234_5678, 6'd0));
   endtask

   // Fill to capacity, hit the full and duplicate answers, then do the longest shift
   task automatic test_full_table();
      int offset;
      int i;
      offset = $urandom_range(0, 255);
      push_request(make_request(KIND_CLEAR, 8'h00, 32'h0, 6'd0));
      for (i = 0; i < CAPACITY_DEF; i++)
         push_request(make_request(KIND_INSERT, 8'((i * 37 + offset) % 256), $urandom,
                                   6'($urandom)));
      push_request(make_request(KIND_INSERT, 8'((64 * 37 + offset) % 256), $urandom, 6'd0));
      push_request(make_request(KIND_INSERT, 8'(offset), $urandom, 6'd0));
      push_request(make_request(KIND_READ, 8'h00, 32'h0, 6'd63));
      push_request(make_request(KIND_READ, 8'h00, 32'h0, 6'd0));
      push_request(make_request(KIND_REMOVE, 8'(offset), 32'h0, 6'd0));
      push_request(make_request(KIND_READ, 8'h00, 32'h0, 6'd63));
      push_request(make_request(KIND_LOOKUP, 8'((63 * 37 + offset) % 256), 32'h0, 6'd0));
      push_request(make_request(KIND_REMOVE, 8'((63 * 37 + offset) % 256), 32'h0, 6'd0));
      push_request(make_request(KIND_INSERT, 8'(offset), $urandom, 6'd0));
      push_request(make_request(KIND_LOOKUP, 8'(offset), 32'h0, 6'd0));
      push_request(make_request(KIND_READ, 8'h00, 32'h0, 6'd62));
   endtask

   // Hold the result side off while requests keep coming, so the block backs up
   task automatic test_backpressure();
      int i;
      hold_request = HOLD_OFF_CYCLES;
      burst_left   = 60;
      for (i = 0; i < 40; i++)
         push_request(random_request(50, 256));
   endtask

   // Epochs that push the table toward full or empty over narrow or wide key sets
   task automatic test_random_traffic();
      int items_left;
      int epoch_len;
      int insert_pct;
      int key_span;
      items_left = RANDOM_ITEMS;
      while (items_left > 0) begin
         epoch_len = $urandom_range(80, 200);
         if (epoch_len > items_left)
            epoch_len = items_left;
         case ($urandom_range(0, 2))
            0:       insert_pct = 20;
            1:       insert_pct = 50;
            default: insert_pct = 75;
         endcase
         case ($urandom_range(0, 2))
            0:       key_span = 16;
            1:       key_span = 80;
            default: key_span = 256;
         endcase
         repeat (epoch_len) push_request(random_request(insert_pct, key_span));
         items_left -= epoch_len;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each result transfer with the oldest pending result
   always @(posedge clock) begin : check_results
      sst_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with none pending: 0x%0h", rsp_data);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("found", 32'(want.found), 32'(rsp_data.found));
            check_field("key_out", 32'(want.key_out), 32'(rsp_data.key_out));
            check_field("value_out", want.value_out, rsp_data.value_out);
            check_field("position_out", 32'(want.position_out), 32'(rsp_data.position_out));
            check_field("count", 32'(want.count), 32'(rsp_data.count));
         end
      end
   end

   // Result side: random stall styles, plus a long hold when requested
   initial begin : result_stalls
      int       hold_left;
      int       phase_left;
      int       stall_style;
      bit [2:0] pattern_tick;
      hold_left    = 0;
      phase_left   = 0;
      stall_style  = 0;
      pattern_tick = '0;
      rsp_ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               stall_style = $urandom_range(0, 3);
               phase_left  = $urandom_range(20, 200);
            end
            phase_left--;
            pattern_tick++;
            case (stall_style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= ($urandom_range(0, 1) == 0);
               default: rsp_ready <= (pattern_tick[1:0] != 2'd0);
            endcase
         end
      end
   end

   // Stop a hung run
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : run_tests
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      mismatch_count = 0;
      burst_left     = 0;
      hold_request   = 0;
      entry_total    = 0;
      foreach (key_valid[k]) key_valid[k] = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_table();
      test_backpressure();
      test_random_traffic();

      // drop valid and drain
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
